/* hdl/tcaq_pkg.sv */
// shared types, codes and default sizes for the two-class age-ordered queue
// no dependencies; imported by every module of the block
package tcaq_pkg;

	// default sizes, handed down from the top level
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int VALUE_BITS_DEF  = 16;

	// fixed widths of the item and result fields
	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 16;
	localparam int ORDER_W  = 8;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_ENQ     = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_DEQ_ANY = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_DEQ_C0  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_DEQ_C1  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// per-class queue commands
	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctrl_t;

	// per-class queue status
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	// one result item
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                cls;
		logic [VALUE_W-1:0]  value;
		logic [ORDER_W-1:0]  order;
	} result_t;

endpackage

/* hdl/tcaq_fifo.sv */
// one class queue: entry memory, head/tail/count pointers, registered head entry
// depends on tcaq_pkg
module tcaq_fifo #(
	parameter int DEPTH  = tcaq_pkg::QUEUE_DEPTH_DEF,
	parameter int DATA_W = tcaq_pkg::VALUE_BITS_DEF + tcaq_pkg::ORDER_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcaq_pkg::fifo_ctrl_t ctrl,
	input  logic [DATA_W-1:0]    wr_data,
	output tcaq_pkg::fifo_stat_t stat,
	output logic [DATA_W-1:0]    head_data
);
	import tcaq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] rd_q;
	logic [PTR_W-1:0]  head_d;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head_d = ctrl.pop ? ptr_inc(head_q) : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= ptr_inc(tail_q);
			end
			head_q <= head_d;
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// entry memory with the next head entry read ahead; bypass when it is being written
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= wr_data;
		end
		if (ctrl.push && (tail_q == head_d)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[head_d];
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign head_data  = rd_q;

endmodule

/* hdl/tcaq_sched.sv */
// operation decode: picks the queue, issues push/pop, forms the result item
// depends on tcaq_pkg
module tcaq_sched #(
	parameter int VALUE_BITS = tcaq_pkg::VALUE_BITS_DEF
) (
	input  logic                                        go,
	input  logic [tcaq_pkg::OPCODE_W-1:0]               opcode,
	input  logic                                        item_class,
	input  logic [tcaq_pkg::ORDER_W-1:0]                next_order,
	input  tcaq_pkg::fifo_stat_t                        stat0,
	input  tcaq_pkg::fifo_stat_t                        stat1,
	input  logic [VALUE_BITS+tcaq_pkg::ORDER_W-1:0]     head0,
	input  logic [VALUE_BITS+tcaq_pkg::ORDER_W-1:0]     head1,
	output tcaq_pkg::fifo_ctrl_t                        ctrl0,
	output tcaq_pkg::fifo_ctrl_t                        ctrl1,
	output tcaq_pkg::result_t                           res
);
	import tcaq_pkg::*;

	logic [ORDER_W-1:0]    order0;
	logic [ORDER_W-1:0]    order1;
	logic [ORDER_W-1:0]    age_diff;
	logic                  older1;
	logic                  sel;
	logic                  sel_empty;
	logic                  tgt_full;
	logic [VALUE_BITS-1:0] sel_value;
	logic [ORDER_W-1:0]    sel_order;

	assign order0   = head0[VALUE_BITS +: ORDER_W];
	assign order1   = head1[VALUE_BITS +: ORDER_W];
	assign age_diff = order0 - order1;
	// class 1 head is older when the wrapped difference lies in the lower half, non-zero
	assign older1   = (age_diff != '0) && !age_diff[ORDER_W-1];

	always_comb begin
		sel = 1'b0;
		unique case (opcode)
			OP_ENQ:     sel = item_class;
			OP_DEQ_ANY: begin
				if (stat0.empty && stat1.empty) begin
					sel = 1'b0;
				end else if (stat0.empty) begin
					sel = 1'b1;
				end else if (stat1.empty) begin
					sel = 1'b0;
				end else begin
					sel = older1;
				end
			end
			OP_DEQ_C0:  sel = 1'b0;
			OP_DEQ_C1:  sel = 1'b1;
		endcase
	end

	assign sel_empty = sel ? stat1.empty : stat0.empty;
	assign tgt_full  = sel ? stat1.full : stat0.full;
	assign sel_value = sel ? head1[VALUE_BITS-1:0] : head0[VALUE_BITS-1:0];
	assign sel_order = sel ? order1 : order0;

	always_comb begin
		ctrl0 = '0;
		ctrl1 = '0;
		res   = '0;
		res.cls = sel;
		if (opcode == OP_ENQ) begin
			ctrl0.push = go && !tgt_full && !sel;
			ctrl1.push = go && !tgt_full && sel;
			res.status = tgt_full ? ST_FULL : ST_OK;
			res.order  = tgt_full ? '0 : next_order;
		end else begin
			ctrl0.pop  = go && !sel_empty && !sel;
			ctrl1.pop  = go && !sel_empty && sel;
			res.status = sel_empty ? ST_EMPTY : ST_OK;
			res.value  = sel_empty ? '0 : VALUE_W'(sel_value);
			res.order  = sel_empty ? '0 : sel_order;
		end
	end

endmodule

/* hdl/two_class_age_ordered_queue_core.sv */
// an accepted item is held in the input register stage; its result is registered as it is served
// throughput: one item per cycle unless the result channel stalls; the queue pointers,
//   read-ahead heads and, on an enqueue, the order counter update as the item is served
// reset (arst_n low): both queues empty, order counter zero, no item held;
//   the entry memories are not cleared
// depends on tcaq_pkg, tcaq_fifo, tcaq_sched
module two_class_age_ordered_queue_core #(
	parameter int QUEUE_DEPTH = tcaq_pkg::QUEUE_DEPTH_DEF,
	parameter int VALUE_BITS  = tcaq_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tcaq_pkg::OPCODE_W-1:0] opcode,
	input  logic                          item_class,
	input  logic [tcaq_pkg::VALUE_W-1:0]  item_value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcaq_pkg::STATUS_W-1:0] status,
	output logic                          out_class,
	output logic [tcaq_pkg::VALUE_W-1:0]  out_value,
	output logic [tcaq_pkg::ORDER_W-1:0]  out_order
);
	import tcaq_pkg::*;

	localparam int ENTRY_W = VALUE_BITS + ORDER_W;

	// input register stage
	logic                valid_s1;
	logic [OPCODE_W-1:0] opcode_s1;
	logic                class_s1;
	logic [VALUE_W-1:0]  value_s1;

	// result register
	logic                out_valid_q;
	result_t             res_q;

	// shared arrival order counter
	logic [ORDER_W-1:0]  next_order_q;

	logic                advance;
	fifo_ctrl_t          ctrl0;
	fifo_ctrl_t          ctrl1;
	fifo_stat_t          stat0;
	fifo_stat_t          stat1;
	logic [ENTRY_W-1:0]  head0;
	logic [ENTRY_W-1:0]  head1;
	logic [ENTRY_W-1:0]  wr_entry;
	result_t             res_d;

	// the held item is served when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the held item, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			class_s1  <= item_class;
			value_s1  <= item_value;
		end
	end

	// new entry: order number above the payload, payload cut to the stored width
	assign wr_entry = {next_order_q, VALUE_BITS'(value_s1)};

	tcaq_fifo #(
		.DEPTH  (QUEUE_DEPTH),
		.DATA_W (ENTRY_W)
	) u_fifo0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl0),
		.wr_data   (wr_entry),
		.stat      (stat0),
		.head_data (head0)
	);

	tcaq_fifo #(
		.DEPTH  (QUEUE_DEPTH),
		.DATA_W (ENTRY_W)
	) u_fifo1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl1),
		.wr_data   (wr_entry),
		.stat      (stat1),
		.head_data (head1)
	);

	tcaq_sched #(
		.VALUE_BITS (VALUE_BITS)
	) u_sched (
		.go         (advance),
		.opcode     (opcode_s1),
		.item_class (class_s1),
		.next_order (next_order_q),
		.stat0      (stat0),
		.stat1      (stat1),
		.head0      (head0),
		.head1      (head1),
		.ctrl0      (ctrl0),
		.ctrl1      (ctrl1),
		.res        (res_d)
	);

	// order counter moves only on an enqueue that was taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_order_q <= '0;
		end else if (ctrl0.push || ctrl1.push) begin
			next_order_q <= next_order_q + ORDER_W'(1);
		end
	end

	// result register, loaded as the held item is served
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign out_class = res_q.cls;
	assign out_value = res_q.value;
	assign out_order = res_q.order;

`ifndef NO_ASSERTIONS
	// a queue command only ever comes from a served item
	a_ctrl_needs_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl0.push || ctrl0.pop || ctrl1.push || ctrl1.pop) |-> advance)
		else $error("queue command without a served item");

	// one item moves at most one queue, one way
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({ctrl0.push, ctrl0.pop, ctrl1.push, ctrl1.pop}) <= 1)
		else $error("more than one queue command at once");

	// never pop an empty queue nor push a full one
	a_no_underflow_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!((ctrl0.pop && stat0.empty) || (ctrl1.pop && stat1.empty)
		|| (ctrl0.push && stat0.full) || (ctrl1.push && stat1.full)))
		else $error("queue underflow or overflow");

	// a taken enqueue hands out the counter value and the counter steps by one
	a_order_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl0.push || ctrl1.push) |=>
		(next_order_q == $past(next_order_q) + ORDER_W'(1)) && out_valid_q
		&& (res_q.order == $past(next_order_q)))
		else $error("order counter out of step with enqueue");
`endif

endmodule
